// ===== hdl/salc_pkg.sv =====
`default_nettype none

package salc_pkg;

	// fixed field widths of the request and result ports
	localparam int KEY_BITS = 32;
	localparam int WAY_BITS = 2;
	localparam int CNT_BITS = 32;

	// front end: idle or reducing a key to its set index
	typedef enum logic {
		F_IDLE,
		F_REDUCE
	} front_state_t;

	// lookup engine: clearing pass, waiting, or working on one request
	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_LOOKUP
	} back_state_t;

	// status from the lookup engine back to the front end
	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/salc_ram.sv =====
`default_nettype none

module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/salc_front.sv =====
`default_nettype none

module salc_front #(
	parameter int NUM_SETS = 256,
	parameter int KEY_WIDTH = 32,
	localparam int TAG_W = (KEY_WIDTH < salc_pkg::KEY_BITS) ? KEY_WIDTH : salc_pkg::KEY_BITS,
	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [salc_pkg::KEY_BITS-1:0] key,
	input  wire logic                         mark_dirty,
	output logic                              q_valid,
	output logic      [TAG_W-1:0]             q_tag,
	output logic      [SW-1:0]                q_set,
	output logic                              q_dirty,
	input  wire salc_pkg::bk_ctl_t            ctl
);

	localparam bit POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam int RW = SW + 1;

	salc_pkg::front_state_t state_q, state_d;

	logic [TAG_W-1:0]              tag_in;
	logic [salc_pkg::KEY_BITS-1:0] key_in;
	logic [SW-1:0]                 set_direct;

	logic [salc_pkg::KEY_BITS-1:0] key_q;
	logic                          dirty_q;
	logic [RW-1:0]                 rem_q, rem_d;
	logic [1:0]                    cnt_q;
	logic [4:0]                    byte_lsb;
	logic [7:0]                    key_byte;

	logic [TAG_W-1:0] fifo_tag_q [2];
	logic [SW-1:0]    fifo_set_q [2];
	logic             fifo_dirty_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             fifo_full;

	logic             enq, load, step;
	logic [TAG_W-1:0] enq_tag;
	logic [SW-1:0]    enq_set;
	logic             enq_dirty;

	// key trimmed to the compared width
	assign tag_in = key[TAG_W-1:0];
	assign key_in = salc_pkg::KEY_BITS'(tag_in);
	assign set_direct = (NUM_SETS == 1) ? '0 : key_in[SW-1:0];

	// remainder by the set count, eight key bits a cycle from the top; the last byte waits while the queue is full
	assign byte_lsb = {~cnt_q, 3'b000};
	assign key_byte = key_q[byte_lsb +: 8];

	always_comb begin
		rem_d = rem_q;
		for (int i = 7; i >= 0; i--) begin
			rem_d = {rem_d[RW-2:0], key_byte[i]};
			if (rem_d >= RW'(NUM_SETS)) begin
				rem_d = rem_d - RW'(NUM_SETS);
			end
		end
	end

	assign fifo_full = (count_q == 2'd2);
	assign full = ctl.clearing || (state_q != salc_pkg::F_IDLE) || fifo_full;

	// front state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		enq       = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		enq_tag   = tag_in;
		enq_set   = set_direct;
		enq_dirty = mark_dirty;
		unique case (state_q)
			salc_pkg::F_IDLE: begin
				if (push && !full) begin
					if (POW2) begin
						enq = 1'b1;
					end else begin
						load    = 1'b1;
						state_d = salc_pkg::F_REDUCE;
					end
				end
			end
			salc_pkg::F_REDUCE: begin
				enq_tag   = key_q[TAG_W-1:0];
				enq_set   = rem_d[SW-1:0];
				enq_dirty = dirty_q;
				if (cnt_q != 2'd3) begin
					step = 1'b1;
				end else if (!fifo_full) begin
					enq     = 1'b1;
					state_d = salc_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = salc_pkg::F_IDLE;
			end
		endcase
	end

	// reducer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= key_in;
			dirty_q <= mark_dirty;
			rem_q   <= '0;
		end else if (step) begin
			rem_q <= rem_d;
		end
	end

	// two-entry request queue toward the lookup engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(enq) - 2'(ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_tag_q[wr_ptr_q]   <= enq_tag;
			fifo_set_q[wr_ptr_q]   <= enq_set;
			fifo_dirty_q[wr_ptr_q] <= enq_dirty;
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_tag   = fifo_tag_q[rd_ptr_q];
	assign q_set   = fifo_set_q[rd_ptr_q];
	assign q_dirty = fifo_dirty_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hdl/salc_back.sv =====
`default_nettype none

module salc_back #(
	parameter int NUM_SETS = 256,
	parameter int WAYS = 4,
	parameter int KEY_WIDTH = 32,
	localparam int TAG_W = (KEY_WIDTH < salc_pkg::KEY_BITS) ? KEY_WIDTH : salc_pkg::KEY_BITS,
	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire logic [TAG_W-1:0]              q_tag,
	input  wire logic [SW-1:0]                 q_set,
	input  wire logic                          q_dirty,
	output salc_pkg::bk_ctl_t                  ctl,
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               hit,
	output logic [salc_pkg::WAY_BITS-1:0]      way,
	output logic                               writeback,
	output logic [salc_pkg::KEY_BITS-1:0]      writeback_key,
	output logic [salc_pkg::CNT_BITS-1:0]      hits_so_far,
	output logic [salc_pkg::CNT_BITS-1:0]      misses_so_far,
	output logic [salc_pkg::CNT_BITS-1:0]      writebacks_so_far
);

	localparam int WIDX = $clog2(WAYS);
	localparam int LRU_LSB = 2 * WAYS;
	localparam int META_W = 2 * WAYS + WAYS * WIDX;
	localparam int ROW_W = WAYS * TAG_W;

	salc_pkg::back_state_t state_q, state_d;

	logic [SW-1:0]    clr_idx_q;
	logic [TAG_W-1:0] tag_q;
	logic [SW-1:0]    set_q;
	logic             dirty_q;
	logic             out_valid_q;
	logic             out_ok;

	logic             issue, lookup, clear;
	logic [ROW_W-1:0]  tag_rd, tag_wr;
	logic [META_W-1:0] meta_rd, meta_wr, meta_init, meta_wdata;
	logic [SW-1:0]     meta_waddr;
	logic              meta_we;

	logic [TAG_W-1:0] tags [WAYS];
	logic [WIDX-1:0]  lru [WAYS];
	logic [WIDX-1:0]  lru_new [WAYS];
	logic [WAYS-1:0]  valid, dirty, valid_new, dirty_new, match;

	logic            hit_any, all_valid, wb;
	logic [WIDX-1:0] hit_way, free_way, victim, target, pos;
	logic [TAG_W-1:0] wb_tag;

	logic                         hit_q, wb_q;
	logic [salc_pkg::WAY_BITS-1:0] way_q;
	logic [salc_pkg::KEY_BITS-1:0] wb_key_q;
	logic [salc_pkg::CNT_BITS-1:0] hit_cnt_q, miss_cnt_q, wb_cnt_q;

	// state row after reset: nothing valid, nothing dirty, ways in order
	always_comb begin
		meta_init = '0;
		for (int r = 0; r < WAYS; r++) begin
			meta_init[LRU_LSB + r * WIDX +: WIDX] = WIDX'(r);
		end
	end

	// engine state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_ok = !out_valid_q || pop;

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		lookup  = 1'b0;
		clear   = 1'b0;
		unique case (state_q)
			salc_pkg::B_CLEAR: begin
				clear = 1'b1;
				if (clr_idx_q == SW'(NUM_SETS - 1)) begin
					state_d = salc_pkg::B_IDLE;
				end
			end
			salc_pkg::B_IDLE: begin
				if (q_valid && out_ok) begin
					issue   = 1'b1;
					state_d = salc_pkg::B_LOOKUP;
				end
			end
			salc_pkg::B_LOOKUP: begin
				lookup  = 1'b1;
				state_d = salc_pkg::B_IDLE;
			end
			default: begin
				state_d = salc_pkg::B_CLEAR;
			end
		endcase
	end

	assign ctl.clearing = (state_q == salc_pkg::B_CLEAR);
	assign ctl.pop      = issue;

	// clearing pass index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (clear) begin
			clr_idx_q <= clr_idx_q + SW'(1);
		end
	end

	// request held while its set is read
	always_ff @(posedge clk) begin
		if (issue) begin
			tag_q   <= q_tag;
			set_q   <= q_set;
			dirty_q <= q_dirty;
		end
	end

	// tag and replacement state memories, one row per set
	salc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (lookup),
		.waddr(set_q),
		.wdata(tag_wr),
		.raddr(q_set),
		.rdata(tag_rd)
	);

	assign meta_we    = clear || lookup;
	assign meta_waddr = clear ? clr_idx_q : set_q;
	assign meta_wdata = clear ? meta_init : meta_wr;

	salc_ram #(
		.WIDTH(META_W),
		.DEPTH(NUM_SETS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(q_set),
		.rdata(meta_rd)
	);

	// unpack the set row
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tags[w] = tag_rd[w * TAG_W +: TAG_W];
			lru[w]  = meta_rd[LRU_LSB + w * WIDX +: WIDX];
		end
		valid = meta_rd[WAYS-1:0];
		dirty = meta_rd[2*WAYS-1:WAYS];
	end

	// tag compare, free way and victim choice
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid[w] && (tags[w] == tag_q);
			if (match[w]) begin
				hit_way = WIDX'(w);
			end
			if (!valid[w]) begin
				free_way = WIDX'(w);
			end
		end
		hit_any   = |match;
		all_valid = &valid;
		victim    = lru[WAYS-1];
		if (hit_any) begin
			target = hit_way;
		end else if (all_valid) begin
			target = victim;
		end else begin
			target = free_way;
		end
		wb     = !hit_any && all_valid && dirty[victim];
		wb_tag = wb ? tags[victim] : '0;
	end

	// move the target way to the front of the recency order
	always_comb begin
		pos = WIDX'(WAYS - 1);
		for (int r = WAYS - 2; r >= 0; r--) begin
			if (lru[r] == target) begin
				pos = WIDX'(r);
			end
		end
		lru_new[0] = target;
		for (int i = 1; i < WAYS; i++) begin
			lru_new[i] = (i <= int'(pos)) ? lru[i-1] : lru[i];
		end
	end

	// updated rows
	always_comb begin
		valid_new = valid;
		dirty_new = dirty;
		valid_new[target] = 1'b1;
		dirty_new[target] = hit_any ? (dirty[target] | dirty_q) : dirty_q;
		tag_wr = tag_rd;
		tag_wr[target * TAG_W +: TAG_W] = tag_q;
		meta_wr = '0;
		meta_wr[WAYS-1:0]      = valid_new;
		meta_wr[2*WAYS-1:WAYS] = dirty_new;
		for (int w = 0; w < WAYS; w++) begin
			meta_wr[LRU_LSB + w * WIDX +: WIDX] = lru_new[w];
		end
	end

	// running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
		end else if (lookup) begin
			hit_cnt_q  <= hit_cnt_q + salc_pkg::CNT_BITS'(hit_any);
			miss_cnt_q <= miss_cnt_q + salc_pkg::CNT_BITS'(!hit_any);
			wb_cnt_q   <= wb_cnt_q + salc_pkg::CNT_BITS'(wb);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lookup) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup) begin
			hit_q    <= hit_any;
			way_q    <= salc_pkg::WAY_BITS'(target);
			wb_q     <= wb;
			wb_key_q <= salc_pkg::KEY_BITS'(wb_tag);
		end
	end

	assign empty             = !out_valid_q;
	assign hit               = hit_q;
	assign way               = way_q;
	assign writeback         = wb_q;
	assign writeback_key     = wb_key_q;
	assign hits_so_far       = hit_cnt_q;
	assign misses_so_far     = miss_cnt_q;
	assign writebacks_so_far = wb_cnt_q;

endmodule

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_lookup.sv =====
// Tag and LRU replacement engine for a set-associative cache. Requests (key, mark_dirty)
// go in through push/full, results (hit, way, writeback, writeback_key, running counts)
// come out through empty/pop, one result per request in request order. The set is the low
// KEY_WIDTH bits of the key modulo NUM_SETS; keys compare on those bits. After reset the engine
// runs a clearing pass over the set state memory with full held high. For each request
// the lookup engine first does the registered read of the set row from the tag and state
// RAMs, then the compare, update and write-back of the row. When NUM_SETS is a power of
// two the front end takes a request every cycle while its two-entry queue is not full;
// otherwise it loads the key and then reduces it 8 bits a cycle, taking no new request
// until the reduced request is in the queue. A request is accepted while the previous
// result still waits to be popped.
`default_nettype none

module set_assoc_lru_cache_lookup #(
	parameter int NUM_SETS = 256,
	parameter int WAYS = 4,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [salc_pkg::KEY_BITS-1:0] key,
	input  wire logic                          mark_dirty,
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               hit,
	output logic [salc_pkg::WAY_BITS-1:0]      way,
	output logic                               writeback,
	output logic [salc_pkg::KEY_BITS-1:0]      writeback_key,
	output logic [salc_pkg::CNT_BITS-1:0]      hits_so_far,
	output logic [salc_pkg::CNT_BITS-1:0]      misses_so_far,
	output logic [salc_pkg::CNT_BITS-1:0]      writebacks_so_far
);

	localparam int TAG_W = (KEY_WIDTH < salc_pkg::KEY_BITS) ? KEY_WIDTH : salc_pkg::KEY_BITS;
	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

	logic              q_valid;
	logic [TAG_W-1:0]  q_tag;
	logic [SW-1:0]     q_set;
	logic              q_dirty;
	salc_pkg::bk_ctl_t ctl;

	// request intake and set index
	salc_front #(
		.NUM_SETS (NUM_SETS),
		.KEY_WIDTH(KEY_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.key       (key),
		.mark_dirty(mark_dirty),
		.q_valid   (q_valid),
		.q_tag     (q_tag),
		.q_set     (q_set),
		.q_dirty   (q_dirty),
		.ctl       (ctl)
	);

	// lookup and replacement
	salc_back #(
		.NUM_SETS (NUM_SETS),
		.WAYS     (WAYS),
		.KEY_WIDTH(KEY_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_tag            (q_tag),
		.q_set            (q_set),
		.q_dirty          (q_dirty),
		.ctl              (ctl),
		.empty            (empty),
		.pop              (pop),
		.hit              (hit),
		.way              (way),
		.writeback        (writeback),
		.writeback_key    (writeback_key),
		.hits_so_far      (hits_so_far),
		.misses_so_far    (misses_so_far),
		.writebacks_so_far(writebacks_so_far)
	);

endmodule

`default_nettype wire
